@@ sv/stut_pkg.sv @@
// ----------------------------------------------------------------------------
// stut_pkg
// Shared types, codes and byte class helpers for the source text tokenizer.
// ----------------------------------------------------------------------------
package stut_pkg;

  // configuration register indexes
  localparam logic [7:0] RegQuote   = 8'd0;
  localparam logic [7:0] RegComment = 8'd1;

  localparam logic [7:0] QuoteReset   = 8'd34;
  localparam logic [7:0] CommentReset = 8'd35;

  localparam logic [7:0] ChEq       = 8'h3d;
  localparam logic [7:0] ChDot      = 8'h2e;
  localparam logic [7:0] ChUnder    = 8'h5f;
  localparam logic [7:0] ChApos     = 8'h27;
  localparam logic [7:0] ChNewline  = 8'h0a;
  localparam logic [1:0] LitLen     = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOI  = 2'd2
  } item_kind_e;

  typedef enum logic [2:0] {
    CLS_NUM  = 3'd0,
    CLS_WORD = 3'd1,
    CLS_STR  = 3'd2,
    CLS_CHR  = 3'd3,
    CLS_SPEC = 3'd4
  } tok_class_e;

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_NUM  = 7'b0000010,
    MODE_WORD = 7'b0000100,
    MODE_STR  = 7'b0001000,
    MODE_CHR  = 7'b0010000,
    MODE_SPEC = 7'b0100000,
    MODE_COMM = 7'b1000000
  } scan_mode_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] tok_byte;
    tok_class_e cls;
    logic       first;
  } res_t;

  // one queue entry: one or two results from a single input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    scan_mode_e mode;
    logic       emit;
  } start_t;

  function automatic logic is_digit(logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b inside {8'h20, 8'h09, 8'h0d, 8'h0a};
  endfunction

  function automatic tok_class_e mode_class(scan_mode_e m);
    tok_class_e c;
    case (m)
      MODE_NUM:  c = CLS_NUM;
      MODE_WORD: c = CLS_WORD;
      MODE_STR:  c = CLS_STR;
      MODE_CHR:  c = CLS_CHR;
      MODE_SPEC: c = CLS_SPEC;
      default:   c = CLS_NUM;
    endcase
    return c;
  endfunction

  // classify a byte seen between tokens
  function automatic start_t classify(logic [7:0] b, logic [7:0] quote, logic [7:0] comment);
    start_t s;
    s.emit = 1'b1;
    if (is_blank(b)) begin
      s.mode = MODE_IDLE;
      s.emit = 1'b0;
    end else if (b == comment) begin
      s.mode = MODE_COMM;
      s.emit = 1'b0;
    end else if (is_digit(b)) begin
      s.mode = MODE_NUM;
    end else if (is_alpha(b)) begin
      s.mode = MODE_WORD;
    end else if (b == quote) begin
      s.mode = MODE_STR;
    end else if (b == ChApos) begin
      s.mode = MODE_CHR;
    end else begin
      s.mode = MODE_SPEC;
    end
    return s;
  endfunction

  function automatic res_t mk_byte(logic [7:0] b, tok_class_e c, logic first);
    res_t r;
    r.kind     = KIND_BYTE;
    r.tok_byte = b;
    r.cls      = c;
    r.first    = first;
    return r;
  endfunction

  function automatic res_t mk_end(tok_class_e c);
    res_t r;
    r.kind     = KIND_END;
    r.tok_byte = 8'd0;
    r.cls      = c;
    r.first    = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_eoi();
    res_t r;
    r.kind     = KIND_EOI;
    r.tok_byte = 8'd0;
    r.cls      = CLS_NUM;
    r.first    = 1'b0;
    return r;
  endfunction

endpackage

@@ sv/stut_front.sv @@
// ----------------------------------------------------------------------------
// stut_front
// Accepts source bytes, runs the scan mode machine and pushes the results of
// each byte into the queue as one entry.
// ----------------------------------------------------------------------------
module stut_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_value_i,
  input  logic                 end_of_input_i,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  stut_pkg::fifo_status_t fifo_status_i,
  output logic                 push_o,
  output stut_pkg::entry_t     entry_o
);

  stut_pkg::scan_mode_e mode_q, mode_d;
  logic [1:0]           lit_cnt_q, lit_cnt_d;
  logic [7:0]           quote_q, comment_q;
  logic                 accept;
  logic                 has_res;
  stut_pkg::start_t     st;
  stut_pkg::entry_t     entry;
  logic [1:0]           lit_inc;

  assign in_ready_o = !fifo_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    st        = stut_pkg::classify(char_value_i, quote_q, comment_q);
    lit_inc   = lit_cnt_q + 2'd1;
    mode_d    = mode_q;
    lit_cnt_d = lit_cnt_q;
    has_res   = 1'b0;
    entry.two = 1'b0;
    entry.r0  = stut_pkg::mk_eoi();
    entry.r1  = stut_pkg::mk_eoi();

    if (end_of_input_i) begin
      has_res   = 1'b1;
      mode_d    = stut_pkg::MODE_IDLE;
      lit_cnt_d = 2'd0;
      if (mode_q inside {stut_pkg::MODE_NUM, stut_pkg::MODE_WORD, stut_pkg::MODE_STR,
                         stut_pkg::MODE_CHR, stut_pkg::MODE_SPEC}) begin
        entry.r0  = stut_pkg::mk_end(stut_pkg::mode_class(mode_q));
        entry.two = 1'b1;
      end
    end else begin
      case (mode_q)
        stut_pkg::MODE_NUM, stut_pkg::MODE_WORD, stut_pkg::MODE_SPEC: begin
          has_res = 1'b1;
          if ((mode_q == stut_pkg::MODE_NUM &&
               (stut_pkg::is_digit(char_value_i) || char_value_i == stut_pkg::ChDot)) ||
              (mode_q == stut_pkg::MODE_WORD &&
               (stut_pkg::is_alpha(char_value_i) || stut_pkg::is_digit(char_value_i) ||
                char_value_i == stut_pkg::ChUnder))) begin
            entry.r0 = stut_pkg::mk_byte(char_value_i, stut_pkg::mode_class(mode_q), 1'b0);
          end else if (mode_q == stut_pkg::MODE_SPEC && char_value_i == stut_pkg::ChEq) begin
            // trailing '=' closes the special token
            entry.r0  = stut_pkg::mk_byte(char_value_i, stut_pkg::CLS_SPEC, 1'b0);
            entry.r1  = stut_pkg::mk_end(stut_pkg::CLS_SPEC);
            entry.two = 1'b1;
            mode_d    = stut_pkg::MODE_IDLE;
          end else begin
            // token ends here, byte then seen as between tokens
            entry.r0  = stut_pkg::mk_end(stut_pkg::mode_class(mode_q));
            entry.r1  = stut_pkg::mk_byte(char_value_i, stut_pkg::mode_class(st.mode), 1'b1);
            entry.two = st.emit;
            mode_d    = st.mode;
            lit_cnt_d = (st.mode == stut_pkg::MODE_CHR) ? 2'd1 : 2'd0;
          end
        end
        stut_pkg::MODE_STR: begin
          has_res  = 1'b1;
          entry.r0 = stut_pkg::mk_byte(char_value_i, stut_pkg::CLS_STR, 1'b0);
          if (char_value_i == quote_q) begin
            entry.r1  = stut_pkg::mk_end(stut_pkg::CLS_STR);
            entry.two = 1'b1;
            mode_d    = stut_pkg::MODE_IDLE;
            lit_cnt_d = 2'd0;
          end
        end
        stut_pkg::MODE_CHR: begin
          has_res   = 1'b1;
          entry.r0  = stut_pkg::mk_byte(char_value_i, stut_pkg::CLS_CHR, 1'b0);
          lit_cnt_d = lit_inc;
          if (lit_inc >= stut_pkg::LitLen) begin
            entry.r1  = stut_pkg::mk_end(stut_pkg::CLS_CHR);
            entry.two = 1'b1;
            mode_d    = stut_pkg::MODE_IDLE;
            lit_cnt_d = 2'd0;
          end
        end
        stut_pkg::MODE_COMM: begin
          if (char_value_i == stut_pkg::ChNewline) begin
            mode_d = stut_pkg::MODE_IDLE;
          end
        end
        default: begin
          has_res   = st.emit;
          entry.r0  = stut_pkg::mk_byte(char_value_i, stut_pkg::mode_class(st.mode), 1'b1);
          mode_d    = st.mode;
          lit_cnt_d = (st.mode == stut_pkg::MODE_CHR) ? 2'd1 : 2'd0;
        end
      endcase
    end
  end

  assign push_o  = accept && has_res;
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stut_pkg::MODE_IDLE;
      lit_cnt_q <= 2'd0;
    end else if (accept) begin
      mode_q    <= mode_d;
      lit_cnt_q <= lit_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q   <= stut_pkg::QuoteReset;
      comment_q <= stut_pkg::CommentReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == stut_pkg::RegQuote) begin
        quote_q <= cfg_data_i;
      end
      if (cfg_index_i == stut_pkg::RegComment) begin
        comment_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ sv/stut_fifo.sv @@
// ----------------------------------------------------------------------------
// stut_fifo
// Short queue of result entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stut_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  stut_pkg::entry_t       wdata_i,
  input  logic                   pop_i,
  output stut_pkg::entry_t       rdata_o,
  output stut_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  stut_pkg::entry_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign rdata_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ sv/stut_back.sv @@
// ----------------------------------------------------------------------------
// stut_back
// Output stage: takes queue entries and sends their one or two results out
// through an output register, marking the last result of each byte.
// ----------------------------------------------------------------------------
module stut_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stut_pkg::entry_t       entry_i,
  input  stut_pkg::fifo_status_t fifo_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output stut_pkg::res_t         out_res_o,
  output logic                   out_last_o
);

  logic           out_valid_q;
  stut_pkg::res_t out_res_q;
  logic           out_last_q;
  logic           pend_valid_q;
  stut_pkg::res_t pend_res_q;
  logic           load_ok;

  assign load_ok = !out_valid_q || out_ready_i;
  assign pop_o   = load_ok && !pend_valid_q && !fifo_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load_ok) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else if (!fifo_status_i.empty) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= entry_i.two;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      if (pend_valid_q) begin
        out_res_q  <= pend_res_q;
        out_last_q <= 1'b1;
      end else begin
        out_res_q  <= entry_i.r0;
        out_last_q <= !entry_i.two;
        pend_res_q <= entry_i.r1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule

@@ sv/source_text_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit
// Byte-stream tokenizer: scanner front end, result queue, output stage.
// A result passes from its byte through a queue entry and then the output register.
// Throughput: one byte per cycle while the queue is not full; a byte that makes two
// results holds the output stage for both, and the queue of FifoDepth entries absorbs it.
// Reset: scan mode goes idle, literal count, queue and output valid clear,
// quote and comment registers return to 34 and 35.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_value
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] token_byte, [10:8] token_class,
                                      // [11] first_of_token, [15:12] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  stut_pkg::fifo_status_t fifo_status;
  stut_pkg::entry_t       push_entry, pop_entry;
  stut_pkg::res_t         out_res;
  logic                   push, pop;

  assign cfg_ready_o = 1'b1;

  stut_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .char_value_i   (s_axis_tdata),
    .end_of_input_i (s_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fifo_status_i  (fifo_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  stut_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_entry),
    .pop_i    (pop),
    .rdata_o  (pop_entry),
    .status_o (fifo_status)
  );

  stut_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (out_res),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, out_res.first, out_res.cls, out_res.tok_byte};
  assign m_axis_tuser = out_res.kind;

  // the scanner never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_status.full))
    else $error("push into full result queue");

  // end of input is always the last result of its byte
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == stut_pkg::KIND_EOI) |-> m_axis_tlast)
    else $error("end of input item without last mark");

  // a token end carries no byte and no first mark
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == stut_pkg::KIND_END) |-> (m_axis_tdata[11:0] == 12'd0 ||
     m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[11]))
    else $error("token end item with byte or first mark");

  // a popped entry always leaves the output busy next cycle
  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid)
    else $error("popped entry not presented");

endmodule

@@ test/source_text_tokenizer_unit_test.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer_unit_test
// Streams source text into the tokenizer. The text holds directed token
// shapes, unclosed tokens at end of input, unusual quote and comment
// settings, and long random token sequences. Every emitted item is predicted
// and compared in order, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module source_text_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1320;
  localparam int unsigned NumSettings = 6;

  // quote / comment pairs that collide with other byte classes
  localparam logic [NumSettings-1:0][7:0] QuoteSet   = {8'h27, 8'h00, 8'hff, 8'h61, 8'h7c, 8'h35};
  localparam logic [NumSettings-1:0][7:0] CommentSet = {8'h20, 8'hff, 8'h00, 8'h3d, 8'h7c, 8'h0a};

  typedef struct {
    stut_pkg::item_kind_e kind;
    logic [7:0]           tok_byte;
    stut_pkg::tok_class_e cls;
    logic                 first;
    logic                 last;
  } tok_item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = 8'd0;
  logic [7:0]  cfg_data_i    = 8'd0;

  // tokenizer state as predicted
  logic [7:0]           quote_reg   = stut_pkg::QuoteReset;
  logic [7:0]           comment_reg = stut_pkg::CommentReset;
  stut_pkg::scan_mode_e scan_state  = stut_pkg::MODE_IDLE;
  stut_pkg::tok_class_e open_cls    = stut_pkg::CLS_NUM;
  logic [1:0]           lit_taken   = 2'd0;

  tok_item_t   step_q[$];
  tok_item_t   token_stream_q[$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_mode     = 0;
  int unsigned stall_left     = 0;
  string       punct_chars    = "+-*/<>=!;:(),{}[]&|%^~?@$";

  source_text_tokenizer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("source_text_tokenizer_unit_test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic digit_byte(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic letter_byte(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic blank_byte(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
  endfunction

  function automatic void add_item(stut_pkg::item_kind_e k, logic [7:0] b,
                                   stut_pkg::tok_class_e c, logic f);
    tok_item_t t;
    t.kind     = k;
    t.tok_byte = b;
    t.cls      = c;
    t.first    = f;
    t.last     = 1'b0;
    step_q.push_back(t);
  endfunction

  function automatic void close_token();
    add_item(stut_pkg::KIND_END, 8'd0, open_cls, 1'b0);
    scan_state = stut_pkg::MODE_IDLE;
    lit_taken  = 2'd0;
  endfunction

  // byte seen between tokens: blanks first, then comment, digit, letter, quote
  function automatic void open_token(logic [7:0] b);
    if (blank_byte(b)) return;
    if (b == comment_reg) begin
      scan_state = stut_pkg::MODE_COMM;
      return;
    end
    if (digit_byte(b)) begin
      scan_state = stut_pkg::MODE_NUM;
      open_cls   = stut_pkg::CLS_NUM;
    end else if (letter_byte(b)) begin
      scan_state = stut_pkg::MODE_WORD;
      open_cls   = stut_pkg::CLS_WORD;
    end else if (b == quote_reg) begin
      scan_state = stut_pkg::MODE_STR;
      open_cls   = stut_pkg::CLS_STR;
    end else if (b == stut_pkg::ChApos) begin
      scan_state = stut_pkg::MODE_CHR;
      open_cls   = stut_pkg::CLS_CHR;
      lit_taken  = 2'd1;
    end else begin
      scan_state = stut_pkg::MODE_SPEC;
      open_cls   = stut_pkg::CLS_SPEC;
    end
    add_item(stut_pkg::KIND_BYTE, b, open_cls, 1'b1);
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eoi);
    step_q.delete();
    if (eoi) begin
      if (scan_state != stut_pkg::MODE_IDLE && scan_state != stut_pkg::MODE_COMM) begin
        close_token();
      end
      add_item(stut_pkg::KIND_EOI, 8'd0, stut_pkg::CLS_NUM, 1'b0);
      scan_state = stut_pkg::MODE_IDLE;
      lit_taken  = 2'd0;
    end else begin
      case (scan_state)
        stut_pkg::MODE_NUM: begin
          if (digit_byte(b) || b == stut_pkg::ChDot) begin
            add_item(stut_pkg::KIND_BYTE, b, stut_pkg::CLS_NUM, 1'b0);
          end else begin
            close_token();
            open_token(b);
          end
        end
        stut_pkg::MODE_WORD: begin
          if (letter_byte(b) || digit_byte(b) || b == stut_pkg::ChUnder) begin
            add_item(stut_pkg::KIND_BYTE, b, stut_pkg::CLS_WORD, 1'b0);
          end else begin
            close_token();
            open_token(b);
          end
        end
        stut_pkg::MODE_STR: begin
          add_item(stut_pkg::KIND_BYTE, b, stut_pkg::CLS_STR, 1'b0);
          if (b == quote_reg) close_token();
        end
        stut_pkg::MODE_CHR: begin
          add_item(stut_pkg::KIND_BYTE, b, stut_pkg::CLS_CHR, 1'b0);
          lit_taken = lit_taken + 2'd1;
          if (lit_taken >= stut_pkg::LitLen) close_token();
        end
        stut_pkg::MODE_SPEC: begin
          if (b == stut_pkg::ChEq) begin
            add_item(stut_pkg::KIND_BYTE, b, stut_pkg::CLS_SPEC, 1'b0);
            close_token();
          end else begin
            close_token();
            open_token(b);
          end
        end
        stut_pkg::MODE_COMM: begin
          if (b == stut_pkg::ChNewline) scan_state = stut_pkg::MODE_IDLE;
        end
        default: open_token(b);
      endcase
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) token_stream_q.push_back(step_q[i]);
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    tok_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (token_stream_q.size() == 0) begin
        $display("%0t: item with nothing predicted: expected none, actual kind %0h data %04h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = token_stream_q.pop_front();
        check_field("item_kind", 8'(want.kind), 8'(m_axis_tuser));
        check_field("token_byte", want.tok_byte, m_axis_tdata[7:0]);
        check_field("token_class", 8'(want.cls), 8'(m_axis_tdata[10:8]));
        check_field("first_of_token", 8'(want.first), 8'(m_axis_tdata[11]));
        check_field("tdata pad", 8'd0, 8'(m_axis_tdata[15:12]));
        check_field("last_of_run", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  // receiver: stretches of full rate, coin flips, sparse accepts and hard stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 60);
    end
    stall_left--;
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= 1'b0;
    endcase
  end

  // ------------------------------------------------------------------ sending

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenize_byte(b, eoi);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic sender_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // blank bytes may still be in flight with nothing predicted, so linger
  task automatic drain_results();
    sender_idle();
    while (token_stream_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == stut_pkg::RegQuote) quote_reg = val;
    else if (idx == stut_pkg::RegComment) comment_reg = val;
  endtask

  function automatic logic [7:0] pick_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1) == 0) return 8'(8'h61 + $urandom_range(0, 25));
    return 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_punct();
    return punct_chars[$urandom_range(0, punct_chars.len() - 1)];
  endfunction

  // one well-formed token with random content, or some noise
  task automatic send_token();
    int unsigned len;
    logic [7:0]  b;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        send_byte(pick_digit(), 1'b0);
        len = $urandom_range(0, 5);
        repeat (len) begin
          send_byte(($urandom_range(0, 3) == 0) ? stut_pkg::ChDot : pick_digit(), 1'b0);
        end
      end
      3, 4, 5: begin
        send_byte(pick_letter(), 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       b = pick_digit();
            1:       b = stut_pkg::ChUnder;
            default: b = pick_letter();
          endcase
          send_byte(b, 1'b0);
        end
      end
      6, 7: begin
        send_byte(quote_reg, 1'b0);
        len = $urandom_range(0, 6);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == quote_reg) b = b ^ 8'h01;
          send_byte(b, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) send_byte(quote_reg, 1'b0);
      end
      8, 9: begin
        send_byte(stut_pkg::ChApos, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      10, 11, 12: begin
        send_byte(pick_punct(), 1'b0);
        if ($urandom_range(0, 1) == 0) send_byte(stut_pkg::ChEq, 1'b0);
      end
      13: begin
        send_byte(comment_reg, 1'b0);
        len = $urandom_range(0, 8);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == stut_pkg::ChNewline) b = 8'h20;
          send_byte(b, 1'b0);
        end
        send_byte(stut_pkg::ChNewline, 1'b0);
      end
      14, 15, 16: begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0:       b = 8'h20;
            1:       b = 8'h09;
            2:       b = 8'h0d;
            default: b = 8'h0a;
          endcase
          send_byte(b, 1'b0);
        end
      end
      17, 18: send_byte(8'($urandom_range(0, 255)), 1'b0);
      default: begin
        if ($urandom_range(0, 1) == 0) send_eoi();
        else send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_token_kinds();
    // word, number, string, char literal, special with '=', special cut by a
    // comment, then top and bottom byte values as specials, one left open
    send_text("a_9\t0.9\"q\"'x'<=+#c\n");
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_eoi();
  endtask

  task automatic test_open_tokens();
    send_text("\"a");
    send_eoi();
    send_text("'z");
    send_eoi();
    send_text("#");
    send_eoi();
    send_eoi();
    send_text("\r7");
    send_eoi();
  endtask

  task automatic test_register_settings();
    for (int i = 0; i < NumSettings; i++) begin
      write_reg(stut_pkg::RegQuote, QuoteSet[i]);
      write_reg(stut_pkg::RegComment, CommentSet[i]);
      repeat (8) begin
        send_token();
        send_byte(($urandom_range(0, 1) == 0) ? quote_reg : comment_reg, 1'b0);
      end
      send_eoi();
    end
    write_reg(stut_pkg::RegQuote, stut_pkg::QuoteReset);
    write_reg(stut_pkg::RegComment, stut_pkg::CommentReset);
  endtask

  task automatic test_random_streams();
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase != 0) begin
        write_reg(stut_pkg::RegQuote,
                  ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : pick_punct());
        write_reg(stut_pkg::RegComment,
                  ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : pick_punct());
      end
      target = items_sent + RandomItems / 4;
      while (items_sent < target) begin
        send_token();
        // late in each phase, hold the sender whenever a burst is nearly spent, until the output has caught up
        if (items_sent >= target - RandomItems / 8 && burst_left == 1) begin
          drain_results();
          burst_left = 0;
        end
      end
      send_eoi();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_token_kinds();
    test_open_tokens();
    test_register_settings();
    test_random_streams();
    sender_idle();
    while (token_stream_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("source_text_tokenizer_unit_test passed");
    else $display("source_text_tokenizer_unit_test failed");
    $finish;
  end

endmodule
